>>> design/gbts_pkg.sv
`timescale 1ns / 1ps

package gbts_pkg;

  // default store size in bytes
  localparam int CAPACITY_DEF = 4096;

  // field widths of the request and result
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 12;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 13;
  localparam int LEN_W   = 13;

  // request function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  // one result
  typedef struct packed {
    logic [CHAR_W-1:0] read_byte;
    logic [LEN_W-1:0]  text_length;
    logic              full_error;
  } res_t;

  // memory port strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic in_ready;
    logic res_valid;
  } seq_st_t;

endpackage

>>> design/gbts_if.sv
`timescale 1ns / 1ps

// request channel
interface gbts_in_if;
  logic                         valid;
  logic                         ready;
  logic [gbts_pkg::FUNC_W-1:0]  func;
  logic [gbts_pkg::POS_W-1:0]   position;
  logic [gbts_pkg::CHAR_W-1:0]  char_value;
  logic [gbts_pkg::COUNT_W-1:0] delete_count;

  modport source (output valid, func, position, char_value, delete_count, input ready);
  modport sink (input valid, func, position, char_value, delete_count, output ready);
endinterface

// result channel
interface gbts_out_if;
  logic                        valid;
  logic                        ready;
  logic [gbts_pkg::CHAR_W-1:0] read_byte;
  logic [gbts_pkg::LEN_W-1:0]  text_length;
  logic                        full_error;

  modport source (output valid, read_byte, text_length, full_error, input ready);
  modport sink (input valid, read_byte, text_length, full_error, output ready);
endinterface

>>> design/gbts_mem.sv
`timescale 1ns / 1ps

module gbts_mem #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  gbts_pkg::mem_ctl_t          ctl,
  input  logic [AW-1:0]               rd_addr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [gbts_pkg::CHAR_W-1:0] wr_data,
  output logic [gbts_pkg::CHAR_W-1:0] rd_data
);

  logic [gbts_pkg::CHAR_W-1:0] mem [CAPACITY];
  logic [gbts_pkg::CHAR_W-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/gbts_seq.sv
`timescale 1ns / 1ps

module gbts_seq #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int PW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [gbts_pkg::FUNC_W-1:0]  in_func,
  input  logic [gbts_pkg::POS_W-1:0]   in_position,
  input  logic [gbts_pkg::CHAR_W-1:0]  in_char_value,
  input  logic [gbts_pkg::COUNT_W-1:0] in_delete_count,
  input  logic                         res_take,
  output gbts_pkg::seq_st_t            st,
  output gbts_pkg::res_t               res,
  output gbts_pkg::mem_ctl_t           mem_ctl,
  output logic [AW-1:0]                mem_rd_addr,
  output logic [AW-1:0]                mem_wr_addr,
  output logic [gbts_pkg::CHAR_W-1:0]  mem_wr_data,
  input  logic [gbts_pkg::CHAR_W-1:0]  mem_rd_data
);

  // compare width wide enough for pointers and request fields
  localparam int CW = (PW > gbts_pkg::COUNT_W) ? PW : gbts_pkg::COUNT_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_MOVE  = 5'b00100,
    S_RWAIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [PW-1:0]               gb_r, gb_nxt;
  logic [PW-1:0]               gf_r, gf_nxt;
  logic [PW-1:0]               len_r, len_nxt;
  logic                        wr_pend_r, wr_pend_nxt;

  gbts_pkg::func_t             func_r, func_nxt;
  logic [gbts_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [gbts_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [PW-1:0]               target_r, target_nxt;
  logic [AW-1:0]               wr_addr_r, wr_addr_nxt;
  logic [gbts_pkg::CHAR_W-1:0] rd_byte_r, rd_byte_nxt;
  logic                        full_r, full_nxt;

  logic [CW-1:0]               pos_w;
  logic [CW-1:0]               len_w;
  logic [CW-1:0]               rem_w;
  logic                        ins_wr;

  assign pos_w = CW'(pos_r);
  assign len_w = CW'(len_r);
  assign rem_w = len_w - pos_w;

  // sequencer: decode, gap move one byte a cycle, edit, hand off result
  always_comb begin
    state_nxt   = state_r;
    gb_nxt      = gb_r;
    gf_nxt      = gf_r;
    len_nxt     = len_r;
    wr_pend_nxt = 1'b0;
    func_nxt    = func_r;
    pos_nxt     = pos_r;
    ch_nxt      = ch_r;
    cnt_nxt     = cnt_r;
    target_nxt  = target_r;
    wr_addr_nxt = wr_addr_r;
    rd_byte_nxt = rd_byte_r;
    full_nxt    = full_r;
    mem_rd_addr = '0;
    mem_ctl     = '0;
    ins_wr      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt    = gbts_pkg::func_t'(in_func);
          pos_nxt     = in_position;
          ch_nxt      = in_char_value;
          cnt_nxt     = CW'(in_delete_count);
          rd_byte_nxt = '0;
          full_nxt    = 1'b0;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        case (func_r)
          gbts_pkg::FN_INSERT: begin
            if (len_r == CAP_P) begin
              full_nxt  = 1'b1;
              state_nxt = S_DONE;
            end else begin
              target_nxt = (pos_w > len_w) ? len_r : PW'(pos_w);
              state_nxt  = S_MOVE;
            end
          end
          gbts_pkg::FN_DELETE: begin
            if (pos_w < len_w) begin
              cnt_nxt    = (cnt_r > rem_w) ? rem_w : cnt_r;
              target_nxt = PW'(pos_w);
              state_nxt  = S_MOVE;
            end else begin
              state_nxt = S_DONE;
            end
          end
          gbts_pkg::FN_READ: begin
            if (pos_w < len_w) begin
              mem_ctl.rd_en = 1'b1;
              mem_rd_addr   = (PW'(pos_w) < gb_r) ? AW'(pos_w)
                                                  : AW'(PW'(pos_w) + gf_r - gb_r);
              state_nxt     = S_RWAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end
          gbts_pkg::FN_CLEAR: begin
            gb_nxt    = '0;
            gf_nxt    = CAP_P;
            len_nxt   = '0;
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MOVE: begin
        if (target_r < gb_r) begin
          // gap moves left: byte below the gap goes to its top end
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = AW'(gb_r - 1'b1);
          wr_pend_nxt   = 1'b1;
          wr_addr_nxt   = AW'(gf_r - 1'b1);
          gb_nxt        = gb_r - 1'b1;
          gf_nxt        = gf_r - 1'b1;
        end else if (target_r > gb_r) begin
          // gap moves right: byte above the gap goes to its bottom end
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = AW'(gf_r);
          wr_pend_nxt   = 1'b1;
          wr_addr_nxt   = AW'(gb_r);
          gb_nxt        = gb_r + 1'b1;
          gf_nxt        = gf_r + 1'b1;
        end else if (!wr_pend_r) begin
          // gap in place and last copy written: apply the edit
          if (func_r == gbts_pkg::FN_INSERT) begin
            ins_wr  = 1'b1;
            gb_nxt  = gb_r + 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            gf_nxt  = gf_r + PW'(cnt_r);
            len_nxt = len_r - PW'(cnt_r);
          end
          state_nxt = S_DONE;
        end
      end
      S_RWAIT: begin
        rd_byte_nxt = mem_rd_data;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // write port: pending copy first, else the inserted byte
    mem_ctl.wr_en = wr_pend_r | ins_wr;
  end

  assign mem_wr_addr = wr_pend_r ? wr_addr_r : AW'(gb_r);
  assign mem_wr_data = wr_pend_r ? mem_rd_data : ch_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      gb_r      <= '0;
      gf_r      <= CAP_P;
      len_r     <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      gb_r      <= gb_nxt;
      gf_r      <= gf_nxt;
      len_r     <= len_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  // request payload and working values
  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    pos_r     <= pos_nxt;
    ch_r      <= ch_nxt;
    cnt_r     <= cnt_nxt;
    target_r  <= target_nxt;
    wr_addr_r <= wr_addr_nxt;
    rd_byte_r <= rd_byte_nxt;
    full_r    <= full_nxt;
  end

  assign st.in_ready    = (state_r == S_IDLE);
  assign st.res_valid   = (state_r == S_DONE);
  assign res.read_byte   = rd_byte_r;
  assign res.text_length = gbts_pkg::LEN_W'(len_r);
  assign res.full_error  = full_r;

endmodule

>>> design/gap_buffer_text_store_unit.sv
`timescale 1ns / 1ps

// Gap buffer text store: holds up to CAPACITY text bytes and takes one
// request at a time (insert, delete run, read, clear), giving one result
// per request. Each request is decoded first; an insert or delete that
// goes ahead then moves the gap to the edit position, waits for the last
// copy to be written and applies the edit, a read in range waits for the
// registered memory read, and a clear, an insert refused on a full store
// and a delete or read at or past the end go straight to the result. The
// byte memory, with one write port and one registered read port, copies
// one byte per cycle across the gap. No clearing pass is run after reset.
// The result waits in an output register, so a stalled result side holds
// the block only once its next result is ready.
module gap_buffer_text_store_unit #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst_n,
  gbts_in_if.sink      in_ch,
  gbts_out_if.source   out_ch
);

  localparam int AW = $clog2(CAPACITY);

  gbts_pkg::seq_st_t           st;
  gbts_pkg::res_t              res;
  gbts_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]               mem_rd_addr;
  logic [AW-1:0]               mem_wr_addr;
  logic [gbts_pkg::CHAR_W-1:0] mem_wr_data;
  logic [gbts_pkg::CHAR_W-1:0] mem_rd_data;
  logic                        in_fire;
  logic                        res_take;

  logic                        out_valid_r;
  gbts_pkg::res_t              out_data_r;

  assign in_ch.ready = st.in_ready;
  assign in_fire     = in_ch.valid & st.in_ready;
  assign res_take    = st.res_valid & (~out_valid_r | out_ch.ready);

  gbts_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_func        (in_ch.func),
    .in_position    (in_ch.position),
    .in_char_value  (in_ch.char_value),
    .in_delete_count(in_ch.delete_count),
    .res_take       (res_take),
    .st             (st),
    .res            (res),
    .mem_ctl        (mem_ctl),
    .mem_rd_addr    (mem_rd_addr),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_data    (mem_rd_data)
  );

  gbts_mem #(
    .CAPACITY(CAPACITY)
  ) u_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .rd_addr(mem_rd_addr),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_data(mem_rd_data)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_byte   = out_data_r.read_byte;
  assign out_ch.text_length = out_data_r.text_length;
  assign out_ch.full_error  = out_data_r.full_error;

  // one request at a time: not ready right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("request taken while previous one still in work");

  // a refused insert only happens with the store full
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.full_error |->
      out_data_r.text_length == gbts_pkg::LEN_W'(CAPACITY))
    else $error("full flag with store not full");

  // a finished result is held until the output register takes it
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st.res_valid && !res_take |=> st.res_valid)
    else $error("finished result dropped");

  // sequencer never accepts while holding a result
  a_ready_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(st.in_ready && st.res_valid))
    else $error("ready while a result is pending");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import gbts_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int POS_MAX    = (1 << POS_W) - 1;
  localparam int QUIET_MAX  = 4 * (CAP + 64);
  localparam int N_RANDOM   = 1850;
  localparam int CALM_SPAN  = 400;

  // one editing request as queued and as seen on the pins
  typedef struct {
    func_t               func;
    logic [POS_W-1:0]    position;
    logic [CHAR_W-1:0]   char_value;
    logic [COUNT_W-1:0]  delete_count;
    bit                  drain_first;
  } edit_req_t;

  logic clk = 1'b0;
  logic rst_n;

  gbts_in_if  req_ch ();
  gbts_out_if res_ch ();

  gap_buffer_text_store_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  edit_req_t         pending[$];
  res_t              expected_results[$];
  logic [CHAR_W-1:0] text_bytes[$];

  int  gen_len;
  int  results_seen;
  int  calm_from;
  int  mismatch_count;
  int  quiet_cycles;
  logic req_taken;
  logic calm;

  // long stretch where neither side idles
  assign calm = (results_seen >= calm_from) && (results_seen < calm_from + CALM_SPAN);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // queue a request and track the text length it leaves behind
  task automatic queue_req(input func_t f, input int pos, input int ch, input int cnt,
                           input bit drain = 1'b0);
    edit_req_t r;
    r.func         = f;
    r.position     = pos[POS_W-1:0];
    r.char_value   = ch[CHAR_W-1:0];
    r.delete_count = cnt[COUNT_W-1:0];
    r.drain_first  = drain;
    case (f)
      FN_INSERT: if (gen_len < CAP) gen_len++;
      FN_DELETE: if (pos < gen_len) gen_len -= (cnt > gen_len - pos) ? gen_len - pos : cnt;
      FN_CLEAR:  gen_len = 0;
      default:   ;
    endcase
    pending.push_back(r);
  endtask

  // text kept as a plain byte sequence; the gap is invisible from outside
  function automatic res_t apply_edit(edit_req_t r);
    res_t res;
    int   at;
    int   span;
    res = '0;
    at  = int'(r.position);
    case (r.func)
      FN_INSERT: begin
        if (text_bytes.size() >= CAP) begin
          res.full_error = 1'b1;
        end else begin
          if (at > text_bytes.size()) at = text_bytes.size();
          text_bytes.insert(at, r.char_value);
        end
      end
      FN_DELETE: begin
        if (at < text_bytes.size()) begin
          span = int'(r.delete_count);
          if (span > text_bytes.size() - at) span = text_bytes.size() - at;
          repeat (span) text_bytes.delete(at);
        end
      end
      FN_READ: begin
        if (at < text_bytes.size()) res.read_byte = text_bytes[at];
      end
      default: text_bytes.delete();
    endcase
    res.text_length = LEN_W'(text_bytes.size());
    return res;
  endfunction

  // request driver, fed from the pending queue
  always @(negedge clk) begin
    edit_req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      res_ch.ready <= 1'b0;
    end else begin
      if (req_ch.valid && !req_taken) begin
        // hold the request until it is taken
      end else if (pending.size() != 0 &&
                   !(pending[0].drain_first && expected_results.size() != 0) &&
                   (calm || $urandom_range(0, 99) >= 31)) begin
        nxt = pending.pop_front();
        req_ch.func         <= nxt.func;
        req_ch.position     <= nxt.position;
        req_ch.char_value   <= nxt.char_value;
        req_ch.delete_count <= nxt.delete_count;
        req_ch.valid        <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  // monitor: predict on request, check on result, watch for a hang
  always @(posedge clk) begin
    edit_req_t got;
    res_t      want;
    logic      req_fire;
    logic      res_fire;
    req_fire = req_ch.valid && req_ch.ready;
    res_fire = res_ch.valid && res_ch.ready;
    if (!rst_n) begin
      req_taken    <= 1'b0;
      quiet_cycles = 0;
    end else begin
      req_taken <= req_fire;
      if (req_fire) begin
        got.func         = func_t'(req_ch.func);
        got.position     = req_ch.position;
        got.char_value   = req_ch.char_value;
        got.delete_count = req_ch.delete_count;
        got.drain_first  = 1'b0;
        expected_results.push_back(apply_edit(got));
      end
      if (res_fire) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("result with nothing pending: byte=%0h len=%0d full=%0b",
                     res_ch.read_byte, res_ch.text_length, res_ch.full_error);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.read_byte !== want.read_byte ||
              res_ch.text_length !== want.text_length ||
              res_ch.full_error !== want.full_error) begin
            if (mismatch_count < 10)
              $display("result %0d: exp byte=%0h len=%0d full=%0b, got %0h %0d %0b",
                       results_seen, want.read_byte, want.text_length, want.full_error,
                       res_ch.read_byte, res_ch.text_length, res_ch.full_error);
            mismatch_count++;
          end
        end
      end
      if (req_fire || res_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("gap_buffer_text_store_unit: mismatch");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int pos;
    int cursor;
    int r;
    int cnt;
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.func         = FN_INSERT;
    req_ch.position     = '0;
    req_ch.char_value   = '0;
    req_ch.delete_count = '0;
    res_ch.ready        = 1'b0;
    gen_len             = 0;
    results_seen        = 0;
    mismatch_count      = 0;
    calm_from           = 0;

    // directed: empty text, clamping, edges of every field
    queue_req(FN_READ,   0,       0,     0);
    queue_req(FN_DELETE, 0,       0,     CAP);
    queue_req(FN_INSERT, POS_MAX, 8'hFF, 0);
    queue_req(FN_INSERT, 0,       8'h00, 0);
    queue_req(FN_INSERT, 1,       8'hA5, 0);
    queue_req(FN_READ,   0,       0,     0);
    queue_req(FN_READ,   1,       0,     0);
    queue_req(FN_READ,   2,       0,     0);
    queue_req(FN_READ,   3,       0,     0);
    queue_req(FN_READ,   POS_MAX, 0,     0);
    queue_req(FN_DELETE, 1,       0,     0);
    queue_req(FN_INSERT, 3,       8'h5A, 0);
    queue_req(FN_DELETE, 4,       0,     1);
    queue_req(FN_DELETE, 2,       0,     CAP);
    queue_req(FN_DELETE, POS_MAX, 0,     1);
    queue_req(FN_READ,   1,       0,     0);
    queue_req(FN_INSERT, 0,       8'h80, 0);
    queue_req(FN_INSERT, 1,       8'h7F, 0);
    queue_req(FN_DELETE, 0,       0,     1);
    queue_req(FN_CLEAR,  POS_MAX, 8'hFF, (1 << COUNT_W) - 1);
    queue_req(FN_READ,   0,       0,     0);
    queue_req(FN_INSERT, 2048,    8'h01, 0);
    queue_req(FN_DELETE, 0,       0,     CAP);

    // fill the whole store, mostly appending
    queue_req(FN_CLEAR, 0, 0, 0);
    while (gen_len < CAP) begin
      if (gen_len > 0 && $urandom_range(0, 9) == 0)
        pos = gen_len - $urandom_range(0, (gen_len < 3) ? gen_len : 3);
      else
        pos = $urandom_range(gen_len, POS_MAX);
      queue_req(FN_INSERT, pos, $urandom_range(0, 255), 0);
    end
    // inserts refused while full
    queue_req(FN_INSERT, 0,       8'h5A, 0);
    queue_req(FN_INSERT, POS_MAX, 8'hC3, 0);
    queue_req(FN_INSERT, $urandom_range(0, POS_MAX), $urandom_range(0, 255), 0);
    queue_req(FN_READ, 0,       0, 0);
    queue_req(FN_READ, POS_MAX, 0, 0);
    repeat (8) queue_req(FN_READ, $urandom_range(0, POS_MAX), 0, 0);
    queue_req(FN_DELETE, POS_MAX, 0,     CAP);
    queue_req(FN_READ,   POS_MAX, 0,     0);
    queue_req(FN_INSERT, POS_MAX, 8'h3C, 0);
    queue_req(FN_INSERT, 2000,    8'h11, 0);
    queue_req(FN_DELETE, 4000,    0,     8);
    // long gap move toward the start
    queue_req(FN_INSERT, 100,     8'hE7, 0);
    queue_req(FN_READ,   100,     0,     0);
    queue_req(FN_READ,   4000,    0,     0);
    queue_req(FN_CLEAR,  0,       0,     0, 1'b1);

    calm_from = pending.size() + 300;

    // random editing around a wandering cursor
    cursor = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) pos = cursor + $urandom_range(0, 8) - 4;
      else if (r < 90) pos = $urandom_range(0, POS_MAX);
      else pos = gen_len + $urandom_range(0, 3);
      if (pos < 0) pos = 0;
      if (pos > POS_MAX) pos = POS_MAX;
      r = $urandom_range(0, 99);
      if (r < 80) cnt = $urandom_range(0, 6);
      else if (r < 95) cnt = $urandom_range(0, CAP);
      else cnt = CAP;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_req(FN_INSERT, pos, $urandom_range(0, 255), cnt, i == 900);
        cursor = ((pos > gen_len) ? gen_len : pos);
      end else if (r < 65) begin
        queue_req(FN_DELETE, pos, $urandom_range(0, 255), cnt, i == 900);
        cursor = pos;
      end else if (r < 97) begin
        queue_req(FN_READ, pos, $urandom_range(0, 255), cnt, i == 900);
      end else begin
        queue_req(FN_CLEAR, pos, $urandom_range(0, 255), cnt, i == 900);
        cursor = 0;
      end
      if (cursor > gen_len) cursor = gen_len;
    end

    // reset, then let the driver work through the queue
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending.size() == 0);
    do @(negedge clk); while (req_ch.valid || expected_results.size() != 0);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("gap_buffer_text_store_unit: match");
    end else begin
      $display("gap_buffer_text_store_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/gbts_pkg.sv
design/gbts_if.sv
design/gbts_mem.sv
design/gbts_seq.sv
design/gap_buffer_text_store_unit.sv
test/tb.sv
